### hw/rtl/lzhbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhbg_pkg
// Shared constants and types of the height-bounded greedy LZ77 parser.
// ----------------------------------------------------------------------------
package lzhbg_pkg;

	localparam int BLOCK_SIZE = 4096;
	localparam int ADDR_W     = $clog2(BLOCK_SIZE);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int HGT_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int MAXH_W     = HGT_W + 1;

	localparam logic [HGT_W-1:0] LIMIT_RESET = 8'd16;
	localparam logic [CNT_W-1:0] MIN_COPY    = CNT_W'(2);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_NONE = 1'b1;

	// memory access request from the search engine
	typedef struct packed {
		logic [ADDR_W-1:0] ta_addr;
		logic [ADDR_W-1:0] tb_addr;
		logic [ADDR_W-1:0] h_raddr;
		logic              h_we;
		logic [ADDR_W-1:0] h_waddr;
		logic [HGT_W-1:0]  h_wdata;
	} mem_req_t;

	// finished phrase from the search engine
	typedef struct packed {
		logic              valid;
		logic [CNT_W-1:0]  length;
		logic [ADDR_W-1:0] source;
		logic              literal;
		logic              last;
	} phrase_t;

endpackage

### hw/rtl/lz_height_bounded_greedy_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_height_bounded_greedy_parser_top
// Loads a block of bytes and returns, per fetch item, one height-bounded greedy
// LZ77 phrase or a no-phrase status.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// s_*      in   tdata: text_byte | tuser: operation | tlast: end_of_block
// m_*      out  tdata: phrase_length, phrase_source | tuser: is_literal, status
//               | tlast: final_phrase
// cfg_*    in   cfg_wdata: height_limit, written when cfg_we is high
//
// A fetch with no phrase to give answers in the next cycle. A fetch that
// searches scans every earlier start of parse position p for the longest
// match whose source heights stay below height_limit, passes a decision
// state, then writes back L heights for a copy of length L or one zero
// height for a literal; the phrase is then registered into the output slot.
// The single read port of each text and height memory gives each compare a
// read state and an evaluate state.
// Reset clears counters and the state machine; the memories need no clearing.
// Input stalls while a search runs or while a result waits on m_tready.
// ----------------------------------------------------------------------------
module lz_height_bounded_greedy_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] operation
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [12:0] phrase_length, [24:13] phrase_source
	output logic [1:0]  m_tuser,   // [0] is_literal, [1] status
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic [lzhbg_pkg::HGT_W-1:0]  limit_q;
	logic [lzhbg_pkg::CNT_W-1:0]  count_q, pos_q;
	logic                         complete_q;

	logic                         out_valid_q;
	logic [lzhbg_pkg::CNT_W-1:0]  out_len_q;
	logic [lzhbg_pkg::ADDR_W-1:0] out_src_q;
	logic                         out_lit_q, out_last_q, out_st_q;

	logic                         eng_busy;
	lzhbg_pkg::mem_req_t          req;
	lzhbg_pkg::phrase_t           res;
	logic [lzhbg_pkg::BYTE_W-1:0] ta_rdata, tb_rdata;
	logic [lzhbg_pkg::HGT_W-1:0]  h_rdata;

	logic                         in_fire, load_fire, fetch_fire;
	logic                         has_phrase, txt_we;
	logic [lzhbg_pkg::ADDR_W-1:0] txt_waddr;
	logic [lzhbg_pkg::CNT_W-1:0]  count_base;

	// Accept only when no search runs and the output slot is or becomes free.
	assign s_tready   = !eng_busy && (!out_valid_q || m_tready);
	assign in_fire    = s_tvalid && s_tready;
	assign load_fire  = in_fire && (s_tuser == lzhbg_pkg::OP_LOAD);
	assign fetch_fire = in_fire && (s_tuser == lzhbg_pkg::OP_FETCH);
	assign has_phrase = complete_q && (pos_q < count_q);

	// A load after the block end restarts the block at position zero.
	assign count_base = complete_q ? '0 : count_q;
	assign txt_we     = load_fire && (count_base < lzhbg_pkg::CNT_W'(lzhbg_pkg::BLOCK_SIZE));
	assign txt_waddr  = count_base[lzhbg_pkg::ADDR_W-1:0];

	// Two text copies give the source and the lookahead read in the same cycle.
	lzhbg_ram #(.WIDTH(lzhbg_pkg::BYTE_W), .DEPTH(lzhbg_pkg::BLOCK_SIZE)) u_text_a (
		.clk   (clk),
		.we    (txt_we),
		.waddr (txt_waddr),
		.wdata (s_tdata),
		.raddr (req.ta_addr),
		.rdata (ta_rdata)
	);

	lzhbg_ram #(.WIDTH(lzhbg_pkg::BYTE_W), .DEPTH(lzhbg_pkg::BLOCK_SIZE)) u_text_b (
		.clk   (clk),
		.we    (txt_we),
		.waddr (txt_waddr),
		.wdata (s_tdata),
		.raddr (req.tb_addr),
		.rdata (tb_rdata)
	);

	// Heights are read below the parse position and written at or above it,
	// so read and write never hit the same entry.
	lzhbg_ram #(.WIDTH(lzhbg_pkg::HGT_W), .DEPTH(lzhbg_pkg::BLOCK_SIZE)) u_height (
		.clk   (clk),
		.we    (req.h_we),
		.waddr (req.h_waddr),
		.wdata (req.h_wdata),
		.raddr (req.h_raddr),
		.rdata (h_rdata)
	);

	lzhbg_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fetch_fire && has_phrase),
		.pos_p    (pos_q),
		.count_n  (count_q),
		.limit    (limit_q),
		.ta_rdata (ta_rdata),
		.tb_rdata (tb_rdata),
		.h_rdata  (h_rdata),
		.busy     (eng_busy),
		.req      (req),
		.res      (res)
	);

	// Block bookkeeping and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= lzhbg_pkg::LIMIT_RESET;
			count_q    <= '0;
			pos_q      <= '0;
			complete_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (load_fire) begin
				if (complete_q) begin
					pos_q <= '0;
				end
				count_q    <= txt_we ? (count_base + lzhbg_pkg::CNT_W'(1)) : count_base;
				complete_q <= s_tlast ? 1'b1 : 1'b0;
			end else if (res.valid) begin
				pos_q <= pos_q + res.length;
			end
		end
	end

	// Output register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid || (fetch_fire && !has_phrase)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_len_q  <= res.length;
			out_src_q  <= res.source;
			out_lit_q  <= res.literal;
			out_last_q <= res.last;
			out_st_q   <= lzhbg_pkg::ST_OK;
		end else if (fetch_fire && !has_phrase) begin
			out_len_q  <= '0;
			out_src_q  <= '0;
			out_lit_q  <= 1'b0;
			out_last_q <= 1'b0;
			out_st_q   <= lzhbg_pkg::ST_NONE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_src_q, out_len_q};
	assign m_tuser  = {out_st_q, out_lit_q};
	assign m_tlast  = out_last_q;

endmodule

### hw/rtl/lzhbg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhbg_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lzhbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/lzhbg_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhbg_engine
// Match search and height write-back sequencer for one phrase.
// ----------------------------------------------------------------------------
module lzhbg_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lzhbg_pkg::CNT_W-1:0]   pos_p,
	input  logic [lzhbg_pkg::CNT_W-1:0]   count_n,
	input  logic [lzhbg_pkg::HGT_W-1:0]   limit,
	input  logic [lzhbg_pkg::BYTE_W-1:0]  ta_rdata,
	input  logic [lzhbg_pkg::BYTE_W-1:0]  tb_rdata,
	input  logic [lzhbg_pkg::HGT_W-1:0]   h_rdata,
	output logic                          busy,
	output lzhbg_pkg::mem_req_t           req,
	output lzhbg_pkg::phrase_t            res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_LIT  = 3'd5;
	localparam logic [2:0] S_WRD  = 3'd6;
	localparam logic [2:0] S_WWR  = 3'd7;

	logic [2:0]                        state_q;
	logic [lzhbg_pkg::ADDR_W-1:0]      pos_q, src_q, best_pos_q;
	logic [lzhbg_pkg::CNT_W-1:0]       len_q, best_len_q, cnt_q;
	logic [lzhbg_pkg::MAXH_W-1:0]      mx_q, best_max_q;

	logic [lzhbg_pkg::CNT_W:0]         run_end;
	logic [lzhbg_pkg::ADDR_W-1:0]      src_inc;
	logic [lzhbg_pkg::MAXH_W-1:0]      h_plus;
	logic                              better;

	assign run_end = {1'b0, pos_p} + {1'b0, len_q};
	assign src_inc = src_q + lzhbg_pkg::ADDR_W'(1);
	assign h_plus  = {1'b0, h_rdata} + lzhbg_pkg::MAXH_W'(1);
	assign better  = (len_q > best_len_q) || ((len_q == best_len_q) && (mx_q < best_max_q));
	assign busy    = (state_q != S_IDLE);

	always_comb begin
		req.ta_addr = pos_q + len_q[lzhbg_pkg::ADDR_W-1:0];
		req.tb_addr = pos_p[lzhbg_pkg::ADDR_W-1:0]
			+ ((state_q == S_RD) ? len_q[lzhbg_pkg::ADDR_W-1:0] : '0);
		req.h_raddr = src_q;
		req.h_we    = (state_q == S_WWR)
			|| ((state_q == S_DONE) && (best_len_q < lzhbg_pkg::MIN_COPY));
		req.h_waddr = pos_p[lzhbg_pkg::ADDR_W-1:0]
			+ ((state_q == S_WWR) ? cnt_q[lzhbg_pkg::ADDR_W-1:0] : '0);
		req.h_wdata = (state_q == S_WWR) ? h_plus[lzhbg_pkg::HGT_W-1:0] : '0;
	end

	always_comb begin
		res.valid   = 1'b0;
		res.length  = best_len_q;
		res.source  = best_pos_q;
		res.literal = 1'b0;
		res.last    = ((pos_p + best_len_q) == count_n);
		if (state_q == S_LIT) begin
			res.valid   = 1'b1;
			res.length  = lzhbg_pkg::CNT_W'(1);
			res.source  = lzhbg_pkg::ADDR_W'(tb_rdata);
			res.literal = 1'b1;
			res.last    = ((pos_p + lzhbg_pkg::CNT_W'(1)) == count_n);
		end else if ((state_q == S_WWR) && ((cnt_q + lzhbg_pkg::CNT_W'(1)) == best_len_q)) begin
			res.valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (pos_p == '0) ? S_DONE : S_RD;
					end
				end
				S_RD: begin
					state_q <= (run_end >= {1'b0, count_n}) ? S_CMP : S_EV;
				end
				S_EV: begin
					state_q <= ((ta_rdata != tb_rdata) || (h_rdata >= limit)) ? S_CMP : S_RD;
				end
				S_CMP: begin
					state_q <= (({1'b0, pos_q} + lzhbg_pkg::CNT_W'(1)) == pos_p) ? S_DONE : S_RD;
				end
				S_DONE: begin
					state_q <= (best_len_q < lzhbg_pkg::MIN_COPY) ? S_LIT : S_WRD;
				end
				S_LIT: begin
					state_q <= S_IDLE;
				end
				S_WRD: begin
					state_q <= S_WWR;
				end
				S_WWR: begin
					state_q <= res.valid ? S_IDLE : S_WRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q      <= '0;
				src_q      <= '0;
				len_q      <= '0;
				mx_q       <= '0;
				best_len_q <= '0;
				best_max_q <= '1;
				best_pos_q <= '0;
			end
			S_EV: begin
				if ((ta_rdata == tb_rdata) && (h_rdata < limit)) begin
					if (h_plus > mx_q) begin
						mx_q <= h_plus;
					end
					len_q <= len_q + lzhbg_pkg::CNT_W'(1);
					src_q <= ({1'b0, src_inc} == pos_p) ? pos_q : src_inc;
				end
			end
			S_CMP: begin
				if (better) begin
					best_len_q <= len_q;
					best_max_q <= mx_q;
					best_pos_q <= pos_q;
				end
				pos_q <= pos_q + lzhbg_pkg::ADDR_W'(1);
				src_q <= pos_q + lzhbg_pkg::ADDR_W'(1);
				len_q <= '0;
				mx_q  <= '0;
			end
			S_DONE: begin
				cnt_q <= '0;
				src_q <= best_pos_q;
			end
			S_WWR: begin
				cnt_q <= cnt_q + lzhbg_pkg::CNT_W'(1);
				src_q <= ({1'b0, src_inc} == pos_p) ? best_pos_q : src_inc;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/lzhbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzhbg_checker
// Port-level checks of the parser's result stream.
// ----------------------------------------------------------------------------
module lzhbg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == 32'd0) && !m_tuser[0] && !m_tlast)
		else $error("no-phrase result carries data");

	a_lit_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] && m_tuser[0] |-> m_tdata[12:0] == 13'd1)
		else $error("literal length not one");

	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] && !m_tuser[0] |-> m_tdata[12:0] >= 13'd2)
		else $error("copy shorter than two");

endmodule

bind lz_height_bounded_greedy_parser_top lzhbg_checker u_lzhbg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
